// ----- hdl/bmg_pkg.sv -----
// Shared constants, types and series tables for the Box-Muller sampler.
`default_nettype none

package bmg_pkg;

  // Field widths
  localparam int UW      = 32;   // uniform input width
  localparam int OUT_W   = 32;   // sample width, signed Q16.16
  localparam int R_W     = 27;   // sqrt(-2 ln u1), Q.24
  localparam int CMAG_W  = 33;   // |cos|, Q.32, can reach exactly 1.0
  localparam int SUM_W   = 35;   // signed series accumulator
  localparam int SQRT_W  = 54;   // radicand width

  // Pipeline shape
  localparam int SQ_ROUNDS    = 32;                          // log2 fraction bits
  localparam int SQRT_STEPS   = 27;                          // root bits
  localparam int LOG_LAT      = SQ_ROUNDS + SQRT_STEPS + 4;
  localparam int SERIES_TERMS = 7;
  localparam int COS_LAT      = 3 * SERIES_TERMS + 6;
  localparam int ALIGN        = LOG_LAT - COS_LAT;
  localparam int PIPE_LAT     = LOG_LAT + 3;

  // Arithmetic constants
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
  localparam logic [31:0] TWO_PI_LO = 32'h487E_D511;   // 2 pi in Q.32, low word
  localparam logic [2:0]  TWO_PI_HI = 3'd6;            // 2 pi in Q.32, high word
  localparam logic [31:0] MEAN_RST  = 32'h0000_0000;
  localparam logic [31:0] STD_RST   = 32'h0001_0000;

  typedef enum logic {
    CFG_MEAN = 1'b0,
    CFG_STD  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              neg;
    logic [CMAG_W-1:0] mag;
  } cos_res_t;

  // Divisor (n+1)(n+2) of series step g
  function automatic logic [7:0] series_div(input logic odd, input logic [2:0] g);
    logic [7:0] d;
    case ({odd, g})
      4'b0000: d = 8'd2;
      4'b0001: d = 8'd12;
      4'b0010: d = 8'd30;
      4'b0011: d = 8'd56;
      4'b0100: d = 8'd90;
      4'b0101: d = 8'd132;
      4'b0110: d = 8'd182;
      4'b1000: d = 8'd6;
      4'b1001: d = 8'd20;
      4'b1010: d = 8'd42;
      4'b1011: d = 8'd72;
      4'b1100: d = 8'd110;
      4'b1101: d = 8'd156;
      4'b1110: d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor); quotient estimate is low by at most one
  function automatic logic [31:0] series_recip(input logic odd, input logic [2:0] g);
    logic [31:0] m;
    case ({odd, g})
      4'b0000: m = 32'd2147483648;
      4'b0001: m = 32'd357913941;
      4'b0010: m = 32'd143165576;
      4'b0011: m = 32'd76695844;
      4'b0100: m = 32'd47721858;
      4'b0101: m = 32'd32537631;
      4'b0110: m = 32'd23598721;
      4'b1000: m = 32'd715827882;
      4'b1001: m = 32'd214748364;
      4'b1010: m = 32'd102261126;
      4'b1011: m = 32'd59652323;
      4'b1100: m = 32'd39045157;
      4'b1101: m = 32'd27531841;
      4'b1110: m = 32'd20452225;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bmg_log_sqrt.sv -----
// Pipelined sqrt(-2 ln u1): normalize, log2 by repeated squaring, scale, integer root.
`default_nettype none

module bmg_log_sqrt import bmg_pkg::*; (
  input  logic          clk,
  input  logic [UW-1:0] u1,
  output logic [R_W-1:0] root
);

  logic [4:0]  lead_pos;
  logic [4:0]  lz;
  logic [31:0] mant;
  logic [5:0]  ipart;

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < UW; i++) begin
      if (u1[i]) begin
        lead_pos = 5'(i);
      end
    end
    lz    = 5'd31 - lead_pos;
    mant  = u1 << lz;
    ipart = {1'b0, lz} + 6'd1;   // UW - lead position
  end

  logic [31:0] m_r  [0:SQ_ROUNDS];
  logic [31:0] f_r  [0:SQ_ROUNDS];
  logic [5:0]  ip_r [0:SQ_ROUNDS];

  always_ff @(posedge clk) begin
    m_r[0]  <= mant;
    f_r[0]  <= '0;
    ip_r[0] <= ipart;
  end

  // One fraction bit per stage: square the Q1.31 mantissa, renormalize.
  for (genvar i = 0; i < SQ_ROUNDS; i++) begin : g_sq
    logic [63:0] sq;
    assign sq = {32'b0, m_r[i]} * {32'b0, m_r[i]};
    always_ff @(posedge clk) begin
      m_r[i+1]  <= sq[63] ? sq[63:32] : sq[62:31];
      f_r[i+1]  <= {f_r[i][30:0], sq[63]};
      ip_r[i+1] <= ip_r[i];
    end
  end

  // t = ipart - frac
  logic [5:0]  t_hi_r;
  logic [31:0] t_lo_r;
  always_ff @(posedge clk) begin
    t_hi_r <= ip_r[SQ_ROUNDS] - {5'b0, |f_r[SQ_ROUNDS]};
    t_lo_r <= 32'b0 - f_r[SQ_ROUNDS];
  end

  // ln2 scaling
  logic [63:0] plo_full;
  logic [31:0] plo_r;
  logic [37:0] phi_r;
  assign plo_full = {32'b0, t_lo_r} * {32'b0, LN2_Q32};
  always_ff @(posedge clk) begin
    plo_r <= plo_full[63:32];
    phi_r <= {32'b0, t_hi_r} * {6'b0, LN2_Q32};
  end

  logic [37:0] w_half;
  assign w_half = phi_r + {6'b0, plo_r};

  logic [SQRT_W-1:0] rem_r [0:SQRT_STEPS];
  logic [SQRT_W-1:0] res_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    rem_r[0] <= {w_half[36:0], 17'b0};   // (2 * w_half) << 16
    res_r[0] <= '0;
  end

  // Restoring root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rt
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * j);
    logic [SQRT_W-1:0] trial;
    logic              take;
    assign trial = res_r[j] + BIT;
    assign take  = rem_r[j] >= trial;
    always_ff @(posedge clk) begin
      rem_r[j+1] <= take ? rem_r[j] - trial : rem_r[j];
      res_r[j+1] <= take ? (res_r[j] >> 1) + BIT : res_r[j] >> 1;
    end
  end

  assign root = res_r[SQRT_STEPS][R_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/bmg_cos.sv -----
// Pipelined cos(2 pi ph): octant fold, Taylor series with reciprocal divides, sign.
`default_nettype none

module bmg_cos import bmg_pkg::*; (
  input  logic          clk,
  input  logic [UW-1:0] ph,
  output cos_res_t      cres
);

  typedef struct packed {
    logic odd;   // sine series
    logic neg;   // quadrant flips the sign
  } ctl_t;

  ctl_t ctl_r [0:COS_LAT-2];

  // Fold to [0, pi/4]
  logic [1:0]  quad;
  logic [29:0] qrem;
  logic [29:0] fold;
  ctl_t        ctl0;

  always_comb begin
    quad = ph[31:30];
    qrem = ph[29:0];
    if (qrem <= 30'h2000_0000) begin
      fold     = qrem;
      ctl0.odd = quad[0];
    end else begin
      fold     = 30'(31'h4000_0000 - {1'b0, qrem});
      ctl0.odd = ~quad[0];
    end
    ctl0.neg = quad[1] ^ quad[0];
  end

  logic [29:0] fold_r;
  always_ff @(posedge clk) begin
    fold_r   <= fold;
    ctl_r[0] <= ctl0;
  end

  for (genvar s = 0; s < COS_LAT - 2; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      ctl_r[s+1] <= ctl_r[s];
    end
  end

  // x = fold * 2pi, split into a low-word and a high-word product
  logic [61:0] xlo_full;
  logic [29:0] xlo_r;
  logic [31:0] xhi_r;
  assign xlo_full = {32'b0, fold_r} * {30'b0, TWO_PI_LO};
  always_ff @(posedge clk) begin
    xlo_r <= xlo_full[61:32];
    xhi_r <= 32'({2'b0, fold_r} * {29'b0, TWO_PI_HI});
  end

  logic [31:0] x_r;
  always_ff @(posedge clk) begin
    x_r <= xhi_r + {2'b0, xlo_r};
  end

  logic [32:0]             gterm_r [0:SERIES_TERMS];
  logic signed [SUM_W-1:0] gsum_r  [0:SERIES_TERMS];
  logic [31:0]             gx2_r   [0:SERIES_TERMS-1];

  logic [63:0] xsq;
  assign xsq = {32'b0, x_r} * {32'b0, x_r};
  always_ff @(posedge clk) begin
    gx2_r[0]   <= xsq[63:32];
    gterm_r[0] <= ctl_r[2].odd ? {1'b0, x_r} : 33'h1_0000_0000;
    gsum_r[0]  <= '0;
  end

  // Each step: term*x^2 (A), reciprocal estimate (B), one correction (C).
  // The previous term is folded into the sum during A.
  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_term
    logic [64:0]             a_prod;
    logic [31:0]             a_n_r;
    logic signed [SUM_W-1:0] a_sum_r;
    logic [31:0]             a_x2_r;
    logic [63:0]             b_prod;
    logic [31:0]             b_q_r;
    logic [31:0]             b_n_r;
    logic signed [SUM_W-1:0] b_sum_r;
    logic [31:0]             b_x2_r;
    logic [7:0]              c_div;
    logic [39:0]             c_rem;
    logic signed [SUM_W-1:0] a_term_s;

    assign a_prod   = {32'b0, gterm_r[g]} * {33'b0, gx2_r[g]};
    assign a_term_s = SUM_W'({2'b0, gterm_r[g]});

    always_ff @(posedge clk) begin
      a_n_r   <= a_prod[63:32];
      a_sum_r <= (g % 2 == 1) ? gsum_r[g] - a_term_s : gsum_r[g] + a_term_s;
      a_x2_r  <= gx2_r[g];
    end

    assign b_prod = {32'b0, a_n_r} *
                    {32'b0, series_recip(ctl_r[4 + 3 * g].odd, 3'(g))};

    always_ff @(posedge clk) begin
      b_q_r   <= b_prod[63:32];
      b_n_r   <= a_n_r;
      b_sum_r <= a_sum_r;
      b_x2_r  <= a_x2_r;
    end

    assign c_div = series_div(ctl_r[5 + 3 * g].odd, 3'(g));
    assign c_rem = {8'b0, b_n_r} - {8'b0, b_q_r} * {32'b0, c_div};

    always_ff @(posedge clk) begin
      gterm_r[g+1] <= {1'b0, b_q_r} + {32'b0, (c_rem >= {32'b0, c_div})};
      gsum_r[g+1]  <= b_sum_r;
    end

    if (g < SERIES_TERMS - 1) begin : g_x2
      always_ff @(posedge clk) begin
        gx2_r[g+1] <= b_x2_r;
      end
    end
  end

  // Last term: series index is odd, so it is subtracted
  logic signed [SUM_W-1:0] fin_sum_r;
  always_ff @(posedge clk) begin
    fin_sum_r <= (SERIES_TERMS % 2 == 1)
               ? gsum_r[SERIES_TERMS] - SUM_W'({2'b0, gterm_r[SERIES_TERMS]})
               : gsum_r[SERIES_TERMS] + SUM_W'({2'b0, gterm_r[SERIES_TERMS]});
  end

  logic signed [SUM_W-1:0] fin_abs;
  logic                    fin_pos;
  assign fin_abs = fin_sum_r[SUM_W-1] ? -fin_sum_r : fin_sum_r;
  assign fin_pos = !fin_sum_r[SUM_W-1] && (fin_sum_r != '0);

  cos_res_t cres_r;
  always_ff @(posedge clk) begin
    cres_r.neg <= ctl_r[COS_LAT-2].neg ? fin_pos : fin_sum_r[SUM_W-1];
    cres_r.mag <= fin_abs[CMAG_W-1:0];
  end

  assign cres = cres_r;

endmodule

`default_nettype wire

// ----- hdl/box_muller_gaussian_sampler.sv -----
// Top level of the Box-Muller Gaussian sampler: request intake, alignment, scaling, saturation.
//
//  Channel  | Ports                                        | Transfer
//  ---------+----------------------------------------------+------------------------------
//  request  | start, busy, in_first_uniform, in_second_... | start && !busy at clk rise
//  result   | out_valid, out_gauss_sample, out_clipped     | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_index, cfg_wdata                 | cfg_we at clk rise
//
// Cycles: fully pipelined, one request per clock; busy is never raised.
// The pipeline is PIPE_LAT (66) register stages deep, set by the log path: 32 squaring
// stages (one 32x32 multiplier each) and 27 root stages.
// A request whose first uniform is zero enters no valid bit and yields no result.
// Reset (rst_n low, synchronous) clears the valid line and loads mean 0, std_dev 1.0.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none

module box_muller_gaussian_sampler import bmg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [UW-1:0]     in_first_uniform,
  input  logic [UW-1:0]     in_second_uniform,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_gauss_sample,
  output logic              out_clipped,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_index,
  input  logic [31:0]       cfg_wdata
);

  // ---- configuration ----
  logic [31:0] mean_r;
  logic [31:0] std_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= MEAN_RST;
      std_r  <= STD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEAN: mean_r <= cfg_wdata;
        CFG_STD:  std_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // ---- request intake ----
  // Every request is taken; u1 == 0 just never gets a valid bit.
  logic accept;
  logic vld_in;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_in = accept && (in_first_uniform != '0);

  logic [PIPE_LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], vld_in};
    end
  end

  // ---- the two datapaths ----
  logic [R_W-1:0] root;
  cos_res_t       cres;

  bmg_log_sqrt u_log_sqrt (
    .clk  (clk),
    .u1   (in_first_uniform),
    .root (root)
  );

  bmg_cos u_cos (
    .clk  (clk),
    .ph   (in_second_uniform),
    .cres (cres)
  );

  // Cos path is shorter; delay it to line up with the root
  cos_res_t cal_r [0:ALIGN-1];
  always_ff @(posedge clk) begin
    cal_r[0] <= cres;
  end
  for (genvar a = 0; a < ALIGN - 1; a++) begin : g_align
    always_ff @(posedge clk) begin
      cal_r[a+1] <= cal_r[a];
    end
  end

  cos_res_t cos_al;
  assign cos_al = cal_r[ALIGN-1];

  // ---- P1: z = r * |c| >> 32, Q.24 ----
  logic [59:0]    z_prod;
  logic [R_W-1:0] z_r;
  logic           neg1_r;
  assign z_prod = {33'b0, root} * {27'b0, cos_al.mag};
  always_ff @(posedge clk) begin
    z_r    <= z_prod[58:32];
    neg1_r <= cos_al.neg;
  end

  // ---- P2: scale by std_dev, round half up on the magnitude ----
  logic [58:0] s_prod;
  logic [34:0] m_r;
  logic        neg2_r;
  assign s_prod = ({32'b0, z_r} * {27'b0, std_r}) + 59'(1 << 23);
  always_ff @(posedge clk) begin
    m_r    <= s_prod[58:24];
    neg2_r <= neg1_r;
  end

  // ---- P3: apply sign, add mean, saturate ----
  logic signed [36:0] total;
  logic               sat_hi;
  logic               sat_lo;
  logic [OUT_W-1:0]   sample_nxt;

  assign total  = $signed({{5{mean_r[31]}}, mean_r})
                + (neg2_r ? -$signed({2'b0, m_r}) : $signed({2'b0, m_r}));
  assign sat_hi = !total[36] && (total[35:31] != '0);
  assign sat_lo = total[36] && (total[35:31] != 5'b11111);

  always_comb begin
    if (sat_hi) begin
      sample_nxt = 32'h7FFF_FFFF;
    end else if (sat_lo) begin
      sample_nxt = 32'h8000_0000;
    end else begin
      sample_nxt = total[31:0];
    end
  end

  logic [OUT_W-1:0] sample_r;
  logic             clip_r;
  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    clip_r   <= sat_hi || sat_lo;
  end

  assign out_valid        = vld_r[PIPE_LAT-1];
  assign out_gauss_sample = sample_r;
  assign out_clipped      = clip_r;

  // ---- checks ----
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_gauss_sample == 32'h7FFF_FFFF || out_gauss_sample == 32'h8000_0000))
    else $error("clipped sample not at a range limit");

  a_zero_u1_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_first_uniform == '0 |=> !vld_r[0])
    else $error("zero first uniform entered the pipeline");

  a_cos_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LOG_LAT-1] |-> (!cos_al.mag[CMAG_W-1] || cos_al.mag[CMAG_W-2:0] == '0))
    else $error("aligned cosine magnitude above 1.0");

  a_entry_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> $past(start))
    else $error("pipeline entry without a request");

endmodule

`default_nettype wire

// ----- verif/box_muller_gaussian_sampler_checker.sv -----
// Checker for the Box-Muller sampler: watches the ports, predicts each sample, compares.
`default_nettype none

module box_muller_gaussian_sampler_checker import bmg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [UW-1:0]    in_first_uniform,
  input  logic [UW-1:0]    in_second_uniform,
  input  logic             out_valid,
  input  logic [OUT_W-1:0] out_gauss_sample,
  input  logic             out_clipped,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [31:0]      cfg_wdata,
  output int               mismatches,
  output int               samples_pending
);

  typedef struct packed {
    logic [31:0] sample;
    logic        clip;
  } gauss_out_t;

  gauss_out_t          expected_samples[$];
  logic signed [31:0]  mean_reg;
  logic [31:0]         std_reg;

  initial mismatches = 0;
  assign samples_pending = expected_samples.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Fractional bits of log2 of a Q1.31 mantissa by repeated squaring
  function automatic logic [63:0] log2_fraction(input logic [63:0] mant);
    logic [63:0] f;
    f = '0;
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      f = f << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        f[0] = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // cos (odd = 0) or sin (odd = 1) of x in Q.32, x <= pi/4
  function automatic logic signed [63:0] taylor_trig(input logic [63:0] x, input bit odd);
    logic [63:0]        x2, term, n;
    logic signed [63:0] sum;
    x2 = (x * x) >> 32;
    term = odd ? x : 64'h1_0000_0000;
    n = odd ? 64'd1 : 64'd0;
    sum = signed'(term);
    for (int k = 0; k < SERIES_TERMS; k++) begin
      term = ((term * x2) >> 32) / ((n + 1) * (n + 2));
      n = n + 2;
      if (k % 2 == 0) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] cos_of_turns(input logic [31:0] ph);
    logic [1:0]         quad;
    logic [29:0]        rem;
    logic [63:0]        f;
    bit                 use_sin;
    logic signed [63:0] v;
    quad = ph[31:30];
    rem = ph[29:0];
    if (rem <= 30'h2000_0000) begin
      f = rem;
      use_sin = quad[0];
    end else begin
      f = 64'h4000_0000 - rem;
      use_sin = !quad[0];
    end
    v = taylor_trig((f * 64'h6_487E_D511) >> 32, use_sin);
    if (quad == 2'd1 || quad == 2'd2) v = -v;
    return v;
  endfunction

  function automatic gauss_out_t gauss_predict(input logic [31:0] u1, input logic [31:0] u2);
    int                 lead;
    logic [63:0]        mant, t, w, r, cmag, z, m;
    logic signed [63:0] c, val;
    gauss_out_t         res;
    lead = 0;
    for (int i = 0; i < 32; i++) if (u1[i]) lead = i;
    mant = 64'(u1) << (31 - lead);
    t = (64'(32 - lead) << 32) - log2_fraction(mant);
    w = 2 * (t[63:32] * 64'(LN2_Q32) + ((t[31:0] * 64'(LN2_Q32)) >> 32));
    r = int_sqrt(w << 16);
    c = cos_of_turns(u2);
    cmag = (c < 0) ? 64'(-c) : 64'(c);
    z = (r * cmag) >> 32;
    m = (z * 64'(std_reg) + (64'd1 << 23)) >> 24;
    val = (c < 0) ? -signed'(m) : signed'(m);
    val = val + 64'(mean_reg);
    res.clip = 1'b0;
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
      res.clip = 1'b1;
    end else if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
      res.clip = 1'b1;
    end
    res.sample = val[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    gauss_out_t want;
    if (!rst_n) begin
      mean_reg <= MEAN_RST;
      std_reg  <= STD_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEAN: mean_reg <= cfg_wdata;
          CFG_STD:  std_reg  <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy && in_first_uniform != '0)
        expected_samples = {expected_samples,
                            gauss_predict(in_first_uniform, in_second_uniform)};
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %h", out_gauss_sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_gauss_sample !== want.sample)
            report_mismatch($sformatf("sample %h, want %h", out_gauss_sample, want.sample));
          if (out_clipped !== want.clip)
            report_mismatch($sformatf("clipped %b, want %b", out_clipped, want.clip));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/box_muller_gaussian_sampler_test.sv -----
// Testbench top for the Box-Muller sampler: clock, reset, requests, config phases, verdict.
`default_nettype none

module box_muller_gaussian_sampler_test;
  import bmg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;   // watchdog bound on the clock cycles of one run
  localparam int RAND_PER_PHASE = 185;   // six phases, about 1100 random requests

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [UW-1:0]    in_first_uniform;
  logic [UW-1:0]    in_second_uniform;
  logic             out_valid;
  logic [OUT_W-1:0] out_gauss_sample;
  logic             out_clipped;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [31:0]      cfg_wdata;
  int               mismatches;
  int               samples_pending;
  int               cycles;
  int               idle_pct;

  box_muller_gaussian_sampler i_dut (.*);

  box_muller_gaussian_sampler_checker i_checker (.*);

  // 8-unit clock period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** box_muller_gaussian_sampler: FAILED **");
      $finish;
    end
  end

  // One request: optional idle cycles first (start low), then hold start until accepted.
  // Start stays high into the next request when no idle cycle follows.
  task automatic send_request(input logic [31:0] u1, input logic [31:0] u2);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    in_first_uniform  <= u1;
    in_second_uniform <= u2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Let the pipeline empty: zero-u1 requests leave no expectation, so add the full latency.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (samples_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random u1: mostly full-range, with tiny values (deep tail), near-one values and zeros
  function automatic logic [31:0] pick_first();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 20) return $urandom >> $urandom_range(31, 1);
    if (sel < 28) return 32'hFFFF_FFFF - $urandom_range(255);
    return $urandom;
  endfunction

  // Random u2: mostly full-range, some near octant and quadrant boundaries
  function automatic logic [31:0] pick_second();
    if ($urandom_range(9) < 2)
      return ($urandom_range(7) << 29) + $urandom_range(4) - 2;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] mean_set[6];
    logic [31:0] std_set[6];
    int          idle_set[6];

    mean_set = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000,
                 32'hFFFE_8000, 32'h0000_0000};
    std_set  = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0200_0000,
                 32'h0000_4000, 32'h7FFF_FFFF};
    idle_set = '{0, 68, 24, 0, 68, 24};

    rst_n             = 1'b0;
    start             = 1'b0;
    in_first_uniform  = '0;
    in_second_uniform = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MEAN;
    cfg_wdata         = '0;
    idle_pct          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at reset config: u1 extremes, zero u1, quadrant/octant edges
    send_request(32'h0000_0001, 32'h0000_0000);   // largest radius, cos = 1
    send_request(32'hFFFF_FFFF, 32'h0000_0000);   // smallest radius
    send_request(32'h0000_0000, 32'h1234_5678);   // rejected, no sample
    send_request(32'h8000_0000, 32'h2000_0000);   // octant edge
    send_request(32'h8000_0001, 32'h2000_0001);
    send_request(32'h0001_0000, 32'h4000_0000);   // cos = 0
    send_request(32'h0000_0001, 32'h6000_0000);
    send_request(32'h0000_0001, 32'h8000_0000);   // cos = -1
    send_request(32'h0000_0000, 32'h0000_0000);   // rejected
    send_request(32'h0000_0003, 32'hC000_0000);
    send_request(32'h5555_5555, 32'hE000_0000);
    send_request(32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'h3FFF_FFFF);
    drain_pipe();

    // Saturation both ways: huge std_dev at largest radius
    write_reg(CFG_STD, 32'hFFFF_FFFF);
    write_reg(CFG_MEAN, 32'h7FFF_FFFF);
    send_request(32'h0000_0001, 32'h0000_0000);   // clip high
    send_request(32'h0000_0001, 32'h8000_0000);   // clip low
    send_request(32'hFFFF_FFFF, 32'h4000_0000);
    drain_pipe();
    write_reg(CFG_MEAN, 32'h8000_0000);
    send_request(32'h0000_0001, 32'h8000_0000);   // clip low
    send_request(32'h0000_0001, 32'h0000_0000);
    send_request(32'h0000_0002, 32'hA000_0000);
    drain_pipe();

    // Random phases, each with its own config and idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MEAN, mean_set[ph]);
      write_reg(CFG_STD, std_set[ph]);
      idle_pct = idle_set[ph];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_request(pick_first(), pick_second());
        // hold off mid-phase once until no sample is pending, with requests still to come
        if (ph == 1 && n == RAND_PER_PHASE / 2) begin
          @(negedge clk);
          start <= 1'b0;
          while (samples_pending != 0) @(posedge clk);
        end
      end
      drain_pipe();
    end

    if (mismatches == 0 && samples_pending == 0) begin
      $display("** box_muller_gaussian_sampler: PASSED **");
    end else begin
      $display("** box_muller_gaussian_sampler: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
